>>> rtl/mtwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_pkg
// Shared types, constants and word functions of the MT19937 word generator.
// ----------------------------------------------------------------------------
package mtwg_pkg;

    localparam int WORD_W      = 32;
    localparam int STATE_WORDS = 624;
    localparam int TAP_OFFSET  = 397;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t HIGH_BIT     = 32'h8000_0000;
    localparam word_t LOW_BITS     = 32'h7fff_ffff;
    localparam word_t SEED_MULT    = 32'd1812433253;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;
    localparam word_t DEFAULT_SEED = 32'd5489;

    // request function codes
    localparam logic FUNC_SEED = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    typedef enum logic {
        ST_RUN,
        ST_SEED
    } state_t;

    // control from the sequencer to the seeding unit
    typedef struct packed {
        logic  start;
        logic  step;
        word_t value;
    } seed_cmd_t;

    function automatic word_t mix_pair(word_t hi_src, word_t lo_src, word_t tap);
        word_t y;
        word_t r;
        y = (hi_src & HIGH_BIT) | (lo_src & LOW_BITS);
        r = tap ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic word_t temper(word_t y_in);
        word_t y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> rtl/mtwg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_cell
// One state word of the generator; takes its neighbor's word on each shift.
// ----------------------------------------------------------------------------
module mtwg_cell (
    input  logic           aclk,
    input  logic           shift_en,
    input  mtwg_pkg::word_t d,
    output mtwg_pkg::word_t q
);
    import mtwg_pkg::*;

    word_t word_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

>>> rtl/mtwg_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_seeder
// Knuth multiplier recurrence, one state word per cycle, fed into the chain.
// ----------------------------------------------------------------------------
module mtwg_seeder #(
    parameter int STATE_WORDS = mtwg_pkg::STATE_WORDS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mtwg_pkg::seed_cmd_t cmd,
    input  mtwg_pkg::word_t     tail,
    output mtwg_pkg::word_t     feed,
    output logic                last
);
    import mtwg_pkg::*;

    localparam int CNT_W = $clog2(STATE_WORDS);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    word_t            seed_reg;
    word_t            mixed;
    word_t            prod;

    // seed value is payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            seed_reg <= cmd.value;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.start) begin
            cnt_next = '0;
        end else if (cmd.step) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // previous word sits in the tail cell
    assign mixed = tail ^ (tail >> 30);
    assign prod  = mixed * SEED_MULT;
    assign feed  = (cnt_reg == '0) ? seed_reg : prod + word_t'(cnt_reg);
    assign last  = (cnt_reg == CNT_W'(STATE_WORDS - 1));

endmodule

>>> rtl/mersenne_twister_word_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_word_generator_top
// MT19937 32-bit word generator built as a circular chain of state cells.
// ----------------------------------------------------------------------------
// The 624 state words live in a ring of cells that shifts by one word per
// step. A next request (func = 1) twists the word at the head with its
// neighbor and the tap 397 words on, tempers it and shifts the fresh word in
// at the tail, so next requests are taken one per cycle and the word shows on
// m_word the cycle after acceptance, held until m_ready. A seed request
// (func = 0) gives no result; it is taken in a start cycle, after which the
// seeding loop runs one multiply and add per state word with s_ready low.
// A next request that arrives before any seed is not taken at first: it
// holds s_ready low through a start cycle and the same seeding with seed
// 5489, and is taken in the cycle after that. A pending result on the
// output does not block seed requests; outside seeding, next requests wait
// only when the output register is full and not being drained.
// ----------------------------------------------------------------------------
module mersenne_twister_word_generator_top #(
    parameter int STATE_WORDS = mtwg_pkg::STATE_WORDS,
    parameter int TAP_OFFSET  = mtwg_pkg::TAP_OFFSET
) (
    input  logic            aclk,
    input  logic            aresetn,
    // request channel
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    input  mtwg_pkg::word_t s_seed,
    // result channel
    output logic            m_valid,
    input  logic            m_ready,
    output mtwg_pkg::word_t m_word
);
    import mtwg_pkg::*;

    // sequencer state
    state_t    state_reg, state_next;
    logic      seeded_reg, seeded_next;
    logic      m_valid_reg, m_valid_next;
    word_t     m_word_reg;

    // ring of state cells, cell 0 is the head
    word_t     cell_q [STATE_WORDS];
    word_t     feed;
    logic      shift_en;

    // seeding unit
    seed_cmd_t seed_cmd;
    word_t     seed_feed;
    logic      seed_last;

    word_t     twisted;
    logic      out_room;
    logic      next_take;

    // ------------------------------------------------------------------
    // state cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
        word_t cell_d;
        if (k == STATE_WORDS - 1) begin : g_tail
            assign cell_d = feed;
        end else begin : g_body
            assign cell_d = cell_q[k+1];
        end
        mtwg_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d        (cell_d),
            .q        (cell_q[k])
        );
    end

    // ------------------------------------------------------------------
    // seeding loop
    // ------------------------------------------------------------------
    mtwg_seeder #(
        .STATE_WORDS (STATE_WORDS)
    ) u_seeder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (seed_cmd),
        .tail    (cell_q[STATE_WORDS-1]),
        .feed    (seed_feed),
        .last    (seed_last)
    );

    // twist of the head word; its neighbor and the tap sit at fixed cells
    assign twisted = mix_pair(cell_q[0], cell_q[1], cell_q[TAP_OFFSET]);

    // output register frees up when empty or drained this cycle
    assign out_room  = !m_valid_reg || m_ready;
    assign next_take = s_valid && s_ready && (s_func == FUNC_NEXT);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        s_ready        = 1'b0;
        shift_en       = 1'b0;
        feed           = twisted;
        seed_cmd.start = 1'b0;
        seed_cmd.step  = 1'b0;
        seed_cmd.value = s_seed;
        case (state_reg)
            ST_RUN: begin
                // a seed request always fits; a next one needs a seeded ring
                // and space in the output register
                if (s_func == FUNC_SEED) begin
                    s_ready = 1'b1;
                end else begin
                    s_ready = seeded_reg && out_room;
                end
                if (s_valid && (s_func == FUNC_SEED)) begin
                    seed_cmd.start = 1'b1;
                    state_next     = ST_SEED;
                end else if (s_valid && !seeded_reg) begin
                    // next before any seed: run the default seed first
                    seed_cmd.start = 1'b1;
                    seed_cmd.value = DEFAULT_SEED;
                    state_next     = ST_SEED;
                end else if (s_valid && s_ready) begin
                    shift_en = 1'b1;
                end
            end
            ST_SEED: begin
                seed_cmd.step = 1'b1;
                shift_en      = 1'b1;
                feed          = seed_feed;
                if (seed_last) begin
                    seeded_next = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (next_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (next_take) begin
            m_word_reg <= temper(twisted);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

`ifndef SYNTH
    // no request taken while the ring is being seeded
    a_no_take_in_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED) |-> !s_ready)
        else $error("request taken during seeding");

    // a next request is only taken from a seeded ring
    a_next_needs_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        next_take |-> seeded_reg)
        else $error("next request taken before seeding");

    // an accepted next request shows a result in the following cycle
    a_next_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        next_take |=> m_valid)
        else $error("next request lost its result");

    // the last seeding step returns to run with the ring marked seeded
    a_seed_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED && seed_last) |=> (state_reg == ST_RUN && seeded_reg))
        else $error("seeding did not finish cleanly");
`endif

endmodule
